### hdl/bbau_pkg.sv
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared constants, types and row addressing helpers for the free bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

package bbau_pkg;

  localparam int unsigned MEM_UNITS       = 1024;
  localparam int unsigned MAX_ALLOC_LEVEL = 8;
  localparam int unsigned TOP_LVL         = $clog2(MEM_UNITS);
  localparam int unsigned SIZE_W          = 9;
  localparam int unsigned ADDR_W          = 10;
  localparam int unsigned LVL_W           = 4;
  localparam int unsigned IDX_W           = TOP_LVL;
  localparam int unsigned ROW_SH          = 5;
  localparam int unsigned ROW_W           = 1 << ROW_SH;
  localparam int unsigned ROWS0           = MEM_UNITS >> ROW_SH;
  localparam int unsigned LVL_ONE_ROW     = TOP_LVL - ROW_SH;
  localparam int unsigned NUM_ROWS        = 2 * ROWS0 - 2 + LVL_ONE_ROW + 1;
  localparam int unsigned RA_W            = $clog2(NUM_ROWS);
  localparam int unsigned OFF_W           = TOP_LVL - ROW_SH;
  localparam logic [RA_W-1:0] ROOT_ROW    = RA_W'(NUM_ROWS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_ROW,
    ST_PICK,
    ST_SPLIT,
    ST_FREE,
    ST_MERGE,
    ST_DONE
  } bbau_state_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_ROW,
    RD_FREE,
    RD_SPLIT,
    RD_PARENT
  } bbau_rd_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_PICK,
    WR_SET,
    WR_PAIR
  } bbau_wr_e;

  typedef struct packed {
    logic     start;
    logic     find;
    bbau_rd_e rd;
    bbau_wr_e wr;
    logic     load_out;
  } bbau_cmd_t;

  typedef struct packed {
    logic too_big;
    logic found;
    logic lvl_above;
    logic buddy_free;
  } bbau_sts_t;

  function automatic logic [LVL_W-1:0] size_to_lvl(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] m;
    logic [LVL_W-1:0]  lvl;
    m   = (size == '0) ? '0 : size - SIZE_W'(1);
    lvl = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (m[i]) begin
        lvl = LVL_W'(i + 1);
      end
    end
    return lvl;
  endfunction

  function automatic int unsigned lvl_rows(input int unsigned lvl);
    return (lvl <= LVL_ONE_ROW) ? (ROWS0 >> lvl) : 1;
  endfunction

  function automatic logic [RA_W-1:0] lvl_base(input logic [LVL_W-1:0] lvl);
    logic [RA_W-1:0] b;
    if (lvl <= LVL_W'(LVL_ONE_ROW)) begin
      b = RA_W'(2 * ROWS0) - (RA_W'(2 * ROWS0) >> lvl);
    end else begin
      b = RA_W'(2 * ROWS0 - 2) + RA_W'(lvl - LVL_W'(LVL_ONE_ROW));
    end
    return b;
  endfunction

  function automatic logic [RA_W-1:0] row_of(input logic [LVL_W-1:0] lvl,
                                             input logic [IDX_W-1:0] idx);
    return lvl_base(lvl) + RA_W'(idx >> ROW_SH);
  endfunction

  function automatic logic [ROW_SH-1:0] first_one(input logic [ROW_W-1:0] vec);
    logic [ROW_SH-1:0] pos;
    pos = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        pos = ROW_SH'(i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

### hdl/bbau_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bbau_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 68
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hdl/bbau_datapath.sv
// ----------------------------------------------------------------------------
// Buddy block allocator datapath
// Free bitmap in RAM rows, row flags, level search, split and merge updates.
// ----------------------------------------------------------------------------
`default_nettype none

module bbau_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          kind_i,
  input  wire logic [bbau_pkg::SIZE_W-1:0]   req_size_i,
  input  wire logic [bbau_pkg::ADDR_W-1:0]   block_addr_i,
  input  wire bbau_pkg::bbau_cmd_t           cmd_i,
  output bbau_pkg::bbau_sts_t                sts_o,
  output logic                               ok_o,
  output logic      [bbau_pkg::ADDR_W-1:0]   alloc_addr_o
);

  logic                          kind_q;
  logic [bbau_pkg::LVL_W-1:0]    lvl_q;
  logic [bbau_pkg::ADDR_W-1:0]   addr_q;
  logic [bbau_pkg::LVL_W-1:0]    k_q;
  logic [bbau_pkg::LVL_W-1:0]    node_lvl_q;
  logic [bbau_pkg::IDX_W-1:0]    node_idx_q;
  logic [bbau_pkg::ADDR_W-1:0]   p_q;
  logic                          res_ok_q;
  logic                          rd_vld_q;
  logic                          rd_root_q;
  logic [bbau_pkg::NUM_ROWS-1:0] vld_q;
  logic [bbau_pkg::NUM_ROWS-1:0] nz_q;

  logic [bbau_pkg::TOP_LVL:0]    level_any;
  logic [bbau_pkg::LVL_W-1:0]    k_d;
  logic                          found;
  logic [bbau_pkg::ROW_W-1:0]    row_vec;
  logic [bbau_pkg::OFF_W-1:0]    row_off;
  logic [bbau_pkg::ROW_W-1:0]    ram_rdata;
  logic [bbau_pkg::ROW_W-1:0]    row_data;
  logic [bbau_pkg::ROW_SH-1:0]   pick_bit;
  logic [bbau_pkg::IDX_W-1:0]    pick_idx;
  logic [bbau_pkg::ADDR_W-1:0]   pick_p;
  logic [bbau_pkg::ADDR_W-1:0]   p_d;
  logic [bbau_pkg::ROW_SH-1:0]   node_bit;
  logic [bbau_pkg::ROW_SH-1:0]   buddy_bit;
  logic [bbau_pkg::LVL_W-1:0]    nl;
  logic [bbau_pkg::IDX_W-1:0]    ni;
  logic                          re;
  logic [bbau_pkg::RA_W-1:0]     raddr;
  logic                          we;
  logic [bbau_pkg::RA_W-1:0]     waddr;
  logic [bbau_pkg::ROW_W-1:0]    wdata;

  always_comb begin
    level_any = '0;
    for (int l = 0; l <= bbau_pkg::TOP_LVL; l++) begin
      for (int r = 0; r < bbau_pkg::ROWS0; r++) begin
        if (r < bbau_pkg::lvl_rows(l)) begin
          level_any[l] = level_any[l] | nz_q[bbau_pkg::lvl_base(bbau_pkg::LVL_W'(l)) + r];
        end
      end
    end
  end

  always_comb begin
    k_d   = '0;
    found = 1'b0;
    for (int l = bbau_pkg::TOP_LVL; l >= 0; l--) begin
      if (level_any[l] && (bbau_pkg::LVL_W'(l) >= lvl_q)) begin
        k_d   = bbau_pkg::LVL_W'(l);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    row_vec = '0;
    for (int l = 0; l <= bbau_pkg::TOP_LVL; l++) begin
      for (int r = 0; r < bbau_pkg::ROWS0; r++) begin
        if ((r < bbau_pkg::lvl_rows(l)) && (k_q == bbau_pkg::LVL_W'(l))) begin
          row_vec[r] = nz_q[bbau_pkg::lvl_base(bbau_pkg::LVL_W'(l)) + r];
        end
      end
    end
  end

  assign row_off   = bbau_pkg::OFF_W'(bbau_pkg::first_one(row_vec));
  assign row_data  = rd_vld_q ? ram_rdata
                   : (rd_root_q ? bbau_pkg::ROW_W'(1) : '0);
  assign pick_bit  = bbau_pkg::first_one(row_data);
  assign pick_idx  = node_idx_q | bbau_pkg::IDX_W'(pick_bit);
  assign pick_p    = bbau_pkg::ADDR_W'(pick_idx << node_lvl_q);
  assign p_d       = (cmd_i.wr == bbau_pkg::WR_PICK) ? pick_p : p_q;
  assign node_bit  = node_idx_q[bbau_pkg::ROW_SH-1:0];
  assign buddy_bit = node_bit ^ bbau_pkg::ROW_SH'(1);

  always_comb begin
    nl = node_lvl_q;
    ni = node_idx_q;
    case (cmd_i.rd)
      bbau_pkg::RD_ROW: begin
        nl = k_q;
        ni = bbau_pkg::IDX_W'(row_off) << bbau_pkg::ROW_SH;
      end
      bbau_pkg::RD_FREE: begin
        nl = lvl_q;
        ni = bbau_pkg::IDX_W'(addr_q >> lvl_q);
      end
      bbau_pkg::RD_SPLIT: begin
        nl = node_lvl_q - bbau_pkg::LVL_W'(1);
        ni = bbau_pkg::IDX_W'(p_d >> nl) | bbau_pkg::IDX_W'(1);
      end
      bbau_pkg::RD_PARENT: begin
        nl = node_lvl_q + bbau_pkg::LVL_W'(1);
        ni = node_idx_q >> 1;
      end
      default: begin
        nl = node_lvl_q;
        ni = node_idx_q;
      end
    endcase
  end

  assign re    = (cmd_i.rd != bbau_pkg::RD_NONE);
  assign raddr = bbau_pkg::row_of(nl, ni);

  always_comb begin
    case (cmd_i.wr)
      bbau_pkg::WR_PICK: wdata = row_data & ~(bbau_pkg::ROW_W'(1) << pick_bit);
      bbau_pkg::WR_SET:  wdata = row_data | (bbau_pkg::ROW_W'(1) << node_bit);
      bbau_pkg::WR_PAIR: wdata = row_data & ~(bbau_pkg::ROW_W'(1) << node_bit)
                                          & ~(bbau_pkg::ROW_W'(1) << buddy_bit);
      default:           wdata = row_data;
    endcase
  end

  assign we    = (cmd_i.wr != bbau_pkg::WR_NONE);
  assign waddr = bbau_pkg::row_of(node_lvl_q, node_idx_q);

  bbau_ram #(
    .WIDTH(bbau_pkg::ROW_W),
    .DEPTH(bbau_pkg::NUM_ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      nz_q      <= bbau_pkg::NUM_ROWS'(1) << bbau_pkg::ROOT_ROW;
      rd_vld_q  <= 1'b0;
      rd_root_q <= 1'b0;
    end else begin
      if (re) begin
        rd_vld_q  <= vld_q[raddr];
        rd_root_q <= (raddr == bbau_pkg::ROOT_ROW);
      end
      if (we) begin
        vld_q[waddr] <= 1'b1;
        nz_q[waddr]  <= |wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      kind_q   <= kind_i;
      lvl_q    <= bbau_pkg::size_to_lvl(req_size_i);
      addr_q   <= block_addr_i;
      p_q      <= '0;
      res_ok_q <= 1'b0;
    end else begin
      if (cmd_i.wr == bbau_pkg::WR_PICK) begin
        p_q <= pick_p;
      end
      if ((cmd_i.wr == bbau_pkg::WR_PICK) || (cmd_i.wr == bbau_pkg::WR_SET)) begin
        res_ok_q <= 1'b1;
      end
    end
    if (cmd_i.find) begin
      k_q <= k_d;
    end
    if (re) begin
      node_lvl_q <= nl;
      node_idx_q <= ni;
    end
    if (cmd_i.load_out) begin
      ok_o         <= res_ok_q;
      alloc_addr_o <= p_q;
    end
  end

  assign sts_o.too_big    = kind_q ? (lvl_q > bbau_pkg::LVL_W'(bbau_pkg::TOP_LVL))
                          : ((lvl_q > bbau_pkg::LVL_W'(bbau_pkg::MAX_ALLOC_LEVEL)) ||
                             (lvl_q > bbau_pkg::LVL_W'(bbau_pkg::TOP_LVL)));
  assign sts_o.found      = found;
  assign sts_o.lvl_above  = (node_lvl_q > lvl_q);
  assign sts_o.buddy_free = row_data[buddy_bit] &&
                            (node_lvl_q < bbau_pkg::LVL_W'(bbau_pkg::TOP_LVL));

endmodule

`default_nettype wire

### hdl/bbau_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy block allocator controller
// Sequences search, split and merge steps and owns the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module bbau_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 kind_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire bbau_pkg::bbau_sts_t  sts_i,
  output bbau_pkg::bbau_cmd_t       cmd_o
);

  bbau_pkg::bbau_state_e state_q, state_d;
  logic                  out_vld_q, out_vld_d;
  logic                  load;

  assign load = (state_q == bbau_pkg::ST_DONE) && (!out_vld_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bbau_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = kind_i ? bbau_pkg::ST_FREE : bbau_pkg::ST_FIND;
        end
      end
      bbau_pkg::ST_FIND: begin
        state_d = (sts_i.too_big || !sts_i.found) ? bbau_pkg::ST_DONE : bbau_pkg::ST_ROW;
      end
      bbau_pkg::ST_ROW:   state_d = bbau_pkg::ST_PICK;
      bbau_pkg::ST_PICK,
      bbau_pkg::ST_SPLIT: begin
        state_d = sts_i.lvl_above ? bbau_pkg::ST_SPLIT : bbau_pkg::ST_DONE;
      end
      bbau_pkg::ST_FREE: begin
        state_d = sts_i.too_big ? bbau_pkg::ST_DONE : bbau_pkg::ST_MERGE;
      end
      bbau_pkg::ST_MERGE: begin
        state_d = sts_i.buddy_free ? bbau_pkg::ST_MERGE : bbau_pkg::ST_DONE;
      end
      bbau_pkg::ST_DONE: begin
        if (load) begin
          state_d = bbau_pkg::ST_IDLE;
        end
      end
      default: state_d = bbau_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.start    = 1'b0;
    cmd_o.find     = 1'b0;
    cmd_o.rd       = bbau_pkg::RD_NONE;
    cmd_o.wr       = bbau_pkg::WR_NONE;
    cmd_o.load_out = load;
    case (state_q)
      bbau_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      bbau_pkg::ST_FIND: cmd_o.find = 1'b1;
      bbau_pkg::ST_ROW:  cmd_o.rd   = bbau_pkg::RD_ROW;
      bbau_pkg::ST_PICK: begin
        cmd_o.wr = bbau_pkg::WR_PICK;
        if (sts_i.lvl_above) begin
          cmd_o.rd = bbau_pkg::RD_SPLIT;
        end
      end
      bbau_pkg::ST_SPLIT: begin
        cmd_o.wr = bbau_pkg::WR_SET;
        if (sts_i.lvl_above) begin
          cmd_o.rd = bbau_pkg::RD_SPLIT;
        end
      end
      bbau_pkg::ST_FREE: begin
        if (!sts_i.too_big) begin
          cmd_o.rd = bbau_pkg::RD_FREE;
        end
      end
      bbau_pkg::ST_MERGE: begin
        if (sts_i.buddy_free) begin
          cmd_o.wr = bbau_pkg::WR_PAIR;
          cmd_o.rd = bbau_pkg::RD_PARENT;
        end else begin
          cmd_o.wr = bbau_pkg::WR_SET;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bbau_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

### hdl/buddy_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// Buddy block allocator
// Allocates and frees power-of-two blocks of a 1024-unit memory.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i, in_ready_o | kind_i, req_size_i, block_addr_i
// out     | output    | out_valid_o, out_ready_i | ok_o, alloc_addr_o
//
// A failed allocation goes from the find state straight to the done state.
// A successful allocation passes find, row and pick, then one split step per split level.
// A free passes the free state, then one merge step per merged level.
// The controller returns to idle after each result load before the next transfer is taken.
// Each split or merge level is one read-modify-write of a 32-bit bitmap row.
// Reset clears control and row flags at once; no clearing pass is needed.
// A new request is taken while an earlier result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        kind_i,
  input  wire logic [bbau_pkg::SIZE_W-1:0] req_size_i,
  input  wire logic [bbau_pkg::ADDR_W-1:0] block_addr_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             ok_o,
  output logic      [bbau_pkg::ADDR_W-1:0] alloc_addr_o
);

  bbau_pkg::bbau_cmd_t cmd;
  bbau_pkg::bbau_sts_t sts;

  bbau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bbau_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (kind_i),
    .req_size_i   (req_size_i),
    .block_addr_i (block_addr_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .ok_o         (ok_o),
    .alloc_addr_o (alloc_addr_o)
  );

endmodule

`default_nettype wire

### hdl/bbau_checker.sv
// ----------------------------------------------------------------------------
// Buddy block allocator checker
// Port-level assertions on result delivery, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bbau_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic                        ok_o,
  input wire logic [bbau_pkg::ADDR_W-1:0] alloc_addr_o
);

  logic [1:0] pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_valid_i && in_ready_o) - 2'(out_valid_o && out_ready_i);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ok_o) && $stable(alloc_addr_o))
    else $error("Stalled result changed before its transfer.");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> alloc_addr_o == '0)
    else $error("Failed request returned a nonzero address.");

  a_pend_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 2'd2)
    else $error("More than two requests outstanding.");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("Result offered without an accepted request.");

endmodule

bind buddy_block_allocator_unit bbau_checker u_bbau_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .ok_o         (ok_o),
  .alloc_addr_o (alloc_addr_o)
);

`default_nettype wire
